@@ rtl/ud_pkg.sv @@
// ----------------------------------------------------------------------------
// ud_pkg
// Shared types and constants for the unpremultiply / defringe pixel stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ud_pkg;

   // One stored pixel, first channel in the low byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] third;
      logic [7:0] second;
      logic [7:0] first;
   } pixel_type;

   // Classification of one transaction, handed from front to back
   typedef struct packed {
      logic has_px;   // write the pixel into the row store
      logic emit;     // produce one result pixel
      logic left;     // left neighbor exists
      logic right;    // right neighbor exists and has arrived
      logic up;       // upper neighbor exists
      logic down;     // lower neighbor exists and has arrived
      logic eof;      // result is the last pixel of the frame
   } flags_type;

   localparam int FLAGS_W = $bits(flags_type);

   // Configuration register indexes
   localparam logic [7:0] CSR_FRAME_WIDTH  = 8'd0;
   localparam logic [7:0] CSR_FRAME_HEIGHT = 8'd1;
   localparam logic [7:0] CSR_PREMULT      = 8'd2;
   localparam logic [7:0] CSR_SWAP         = 8'd3;

   localparam logic [7:0] FULL_SCALE = 8'd255;

   // Select one color channel of a pixel
   function automatic logic [7:0] chan_sel(input pixel_type p, input logic [1:0] ch);
      logic [7:0] v;
      case (ch)
         2'd0:    v = p.first;
         2'd1:    v = p.second;
         2'd2:    v = p.third;
         default: v = p.alpha;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/unpremultiply_defringe_pixel_stream.sv @@
// ----------------------------------------------------------------------------
// unpremultiply_defringe_pixel_stream
// Raster pixel stream: alpha unpremultiply with zero-alpha defringe, or alpha
// force to full scale, with optional first/third channel swap.
//
// Usage:
//   req_* carries one pixel per transaction (req_drain set: no pixel, push
//   out the oldest pending pixel). rsp_* returns processed pixels in order;
//   a pixel comes out once frame width + 2 pixels are pending, so results lag
//   one row and one pixel, and drain transactions flush the frame tail.
//   csr_* writes frame_width, frame_height, premultiplied_mode and
//   swap_red_blue (indexes 0..3); write only while the stream is idle.
// Operation:
//   The classifier takes a transaction per cycle into a two-entry queue
//   while the queue is not full. The engine writes a store-only pixel and
//   stays idle; an emitted pixel is fetched and evaluated, then run through
//   the shared 1-bit-per-cycle divider for each of its three channels when
//   it is unpremultiplied; a zero-alpha pixel also evaluates up to 4
//   neighbors, dividing each opaque one. The divider sets the sustained rate.
// Reset clears positions, queue and result register; the row store is not
// cleared. A stalled result holds in the output register while the engine
// keeps working on the next queued transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unpremultiply_defringe_pixel_stream
   import ud_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_drain,
   input  wire logic [7:0]  req_first_channel,
   input  wire logic [7:0]  req_second_channel,
   input  wire logic [7:0]  req_third_channel,
   input  wire logic [7:0]  req_alpha_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_first,
   output logic [7:0]       rsp_out_second,
   output logic [7:0]       rsp_out_third,
   output logic [7:0]       rsp_out_alpha,
   output logic             rsp_end_of_frame,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int Depth = 2 * MAX_WIDTH + 2;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int QW    = FLAGS_W + $bits(pixel_type) + 2 * AW;

   // Configuration registers
   logic [12:0] width_ff, height_ff;
   logic        premult_ff, swap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 13'd640;
         height_ff  <= 13'd480;
         premult_ff <= 1'b0;
         swap_ff    <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff   <= csr_wdata[12:0];
            CSR_FRAME_HEIGHT: height_ff  <= csr_wdata[12:0];
            CSR_PREMULT:      premult_ff <= csr_wdata[0];
            CSR_SWAP:         swap_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp geometry to 1..MAX
   logic [CW-1:0] frame_w;
   logic [RW-1:0] frame_h;

   always_comb begin
      if (width_ff == '0)                frame_w = CW'(1);
      else if (32'(width_ff) > MAX_WIDTH) frame_w = CW'(MAX_WIDTH);
      else                               frame_w = CW'(width_ff);
      if (height_ff == '0)                 frame_h = RW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) frame_h = RW'(MAX_HEIGHT);
      else                                 frame_h = RW'(height_ff);
   end

   pixel_type     req_pixel;
   flags_type     f_flags, b_flags;
   pixel_type     f_pixel, b_pixel;
   logic [AW-1:0] f_ws, f_pslot, b_ws, b_pslot;
   logic          q_push, q_full, q_valid, q_pop;
   logic [QW-1:0] q_wdata, q_rdata;

   assign req_pixel = '{alpha: req_alpha_in, third: req_third_channel,
                        second: req_second_channel, first: req_first_channel};

   ud_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_drain (req_drain),
      .req_pixel (req_pixel),
      .frame_w   (frame_w),
      .frame_h   (frame_h),
      .cmd_push  (q_push),
      .cmd_full  (q_full),
      .cmd_flags (f_flags),
      .cmd_pixel (f_pixel),
      .cmd_ws    (f_ws),
      .cmd_pslot (f_pslot)
   );

   assign q_wdata = {f_flags, f_pixel, f_ws, f_pslot};
   assign {b_flags, b_pixel, b_ws, b_pslot} = q_rdata;

   ud_queue #(.WIDTH(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .valid (q_valid),
      .rdata (q_rdata),
      .pop   (q_pop)
   );

   ud_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_valid),
      .cmd_pop          (q_pop),
      .cmd_flags        (b_flags),
      .cmd_pixel        (b_pixel),
      .cmd_ws           (b_ws),
      .cmd_pslot        (b_pslot),
      .frame_w          (frame_w),
      .premult          (premult_ff),
      .swap             (swap_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_first    (rsp_out_first),
      .rsp_out_second   (rsp_out_second),
      .rsp_out_third    (rsp_out_third),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

@@ rtl/ud_queue.sv @@
// ----------------------------------------------------------------------------
// ud_queue
// Two-entry command queue between the classifier and the execution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ud_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   output logic                  valid,
   output logic [WIDTH-1:0]      rdata,
   input  wire logic             pop
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign rdata = data_ff[rd_ff];

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ff] <= wdata;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ud_front.sv @@
// ----------------------------------------------------------------------------
// ud_front
// Accepts input transactions, tracks store slots and frame position, and
// classifies each transaction into a command for the execution engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ud_front
   import ud_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   localparam int Depth = 2 * MAX_WIDTH + 2,
   localparam int AW    = $clog2(Depth),
   localparam int CW    = $clog2(MAX_WIDTH + 1),
   localparam int RW    = $clog2(MAX_HEIGHT + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          req_drain,
   input  wire pixel_type     req_pixel,
   input  wire logic [CW-1:0] frame_w,
   input  wire logic [RW-1:0] frame_h,
   output logic               cmd_push,
   input  wire logic          cmd_full,
   output flags_type          cmd_flags,
   output pixel_type          cmd_pixel,
   output logic [AW-1:0]      cmd_ws,
   output logic [AW-1:0]      cmd_pslot
);

   localparam int PW = $clog2(Depth + 1);
   localparam int SW = PW + 1;

   logic [AW-1:0] ws_ff, ws_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          accept, has_px, emit;
   logic [PW-1:0] pend_w;
   logic [AW-1:0] ws_n;
   logic [SW-1:0] slot_w;
   logic          col_last, row_last;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;
   assign has_px    = !req_drain;

   // Classify the transaction
   always_comb begin
      pend_w = pend_ff;
      ws_n   = ws_ff;
      if (has_px) begin
         if (pend_ff != PW'(Depth)) pend_w = pend_ff + 1'b1;
         ws_n = (ws_ff == AW'(Depth - 1)) ? '0 : ws_ff + 1'b1;
      end
      if (has_px) emit = (SW'(pend_w) >= SW'(frame_w) + SW'(2));
      else        emit = (pend_ff != '0);

      if (SW'(ws_n) >= SW'(pend_w)) slot_w = SW'(ws_n) - SW'(pend_w);
      else                          slot_w = SW'(ws_n) + SW'(Depth) - SW'(pend_w);

      col_last = ((CW+1)'(col_ff) + 1'b1 >= (CW+1)'(frame_w));
      row_last = ((RW+1)'(row_ff) + 1'b1 >= (RW+1)'(frame_h));

      cmd_flags.has_px = has_px;
      cmd_flags.emit   = emit;
      cmd_flags.left   = (col_ff != '0);
      cmd_flags.right  = !col_last && (pend_w > PW'(1));
      cmd_flags.up     = (row_ff != '0);
      cmd_flags.down   = !row_last && (SW'(pend_w) > SW'(frame_w));
      cmd_flags.eof    = col_last && row_last;
   end

   assign cmd_push  = accept && (has_px || emit);
   assign cmd_pixel = req_pixel;
   assign cmd_ws    = ws_ff;
   assign cmd_pslot = slot_w[AW-1:0];

   // Next slot, pending count and output position
   always_comb begin
      ws_in   = ws_ff;
      pend_in = pend_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         ws_in   = ws_n;
         pend_in = emit ? pend_w - 1'b1 : pend_w;
         if (emit) begin
            if (col_last) begin
               col_in = '0;
               row_in = row_last ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= '0;
         pend_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         ws_ff   <= ws_in;
         pend_ff <= pend_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ud_back.sv @@
// ----------------------------------------------------------------------------
// ud_back
// Execution engine: owns the row store, fetches the pixel and its neighbors,
// unpremultiplies through a shared bit-serial divider, averages, and drives
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ud_back
   import ud_pkg::*;
#(
   parameter int MAX_WIDTH = 4096,
   localparam int Depth = 2 * MAX_WIDTH + 2,
   localparam int AW    = $clog2(Depth),
   localparam int CW    = $clog2(MAX_WIDTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   output logic               cmd_pop,
   input  wire flags_type     cmd_flags,
   input  wire pixel_type     cmd_pixel,
   input  wire logic [AW-1:0] cmd_ws,
   input  wire logic [AW-1:0] cmd_pslot,
   input  wire logic [CW-1:0] frame_w,
   input  wire logic          premult,
   input  wire logic          swap,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_out_first,
   output logic [7:0]         rsp_out_second,
   output logic [7:0]         rsp_out_third,
   output logic [7:0]         rsp_out_alpha,
   output logic               rsp_end_of_frame
);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_WAIT, S_EVAL, S_DIV, S_NEXT, S_AVG, S_OUT
   } state_type;

   // Fetch source codes
   localparam logic [2:0] K_CUR   = 3'd0;
   localparam logic [2:0] K_LEFT  = 3'd1;
   localparam logic [2:0] K_RIGHT = 3'd2;
   localparam logic [2:0] K_UP    = 3'd3;
   localparam logic [2:0] K_DOWN  = 3'd4;

   // Row store
   pixel_type     mem [Depth];
   pixel_type     rdata_ff;
   logic          we, re;
   logic [AW-1:0] raddr;

   always_ff @(posedge clock) begin
      if (we) mem[cmd_ws] <= cmd_pixel;
      if (re) rdata_ff <= mem[raddr];
   end

   state_type     state_ff, state_in;
   flags_type     flags_ff, flags_in;
   logic [AW-1:0] pslot_ff, pslot_in;
   logic [2:0]    k_ff, k_in;
   logic [1:0]    ch_ff, ch_in;
   logic [7:0]    rem_ff, rem_in;
   logic [7:0]    low_ff, low_in;
   logic [7:0]    q_ff, q_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          sat_ff, sat_in;
   pixel_type     pix_ff, pix_in;
   pixel_type     cur_ff, cur_in;
   pixel_type     left_ff, left_in;
   logic [7:0]    res_ff [3];
   logic [7:0]    res_in [3];
   logic [9:0]    sum_ff [3];
   logic [9:0]    sum_in [3];
   logic [2:0]    t_ff, t_in;
   logic          ov_ff, ov_in;
   logic [7:0]    of_ff, of_in, os_ff, os_in, ot_ff, ot_in, oa_ff, oa_in;
   logic          oe_ff, oe_in;

   // Neighbor slot addresses
   logic [AW:0]   wx, up_s, dn_s;
   logic [AW-1:0] right_a, up_a, dn_a;

   always_comb begin
      wx      = (AW+1)'(frame_w);
      right_a = (pslot_ff == AW'(Depth - 1)) ? '0 : pslot_ff + 1'b1;
      if ((AW+1)'(pslot_ff) >= wx) up_s = (AW+1)'(pslot_ff) - wx;
      else                         up_s = (AW+1)'(pslot_ff) + (AW+1)'(Depth) - wx;
      dn_s = (AW+1)'(pslot_ff) + wx;
      if (dn_s >= (AW+1)'(Depth)) dn_s = dn_s - (AW+1)'(Depth);
      up_a = up_s[AW-1:0];
      dn_a = dn_s[AW-1:0];
   end

   // Divider load values for the next channel
   logic [1:0]  ld_ch;
   logic [7:0]  ld_c;
   logic [15:0] ld_n;
   logic [8:0]  r9;
   logic [7:0]  dval;
   logic        ddone;

   always_comb begin
      ld_ch = (state_ff == S_DIV) ? ch_ff + 2'd1 : 2'd0;
      ld_c  = chan_sel(pix_ff, ld_ch);
      ld_n  = {ld_c, 8'h00} - {8'h00, ld_c};
      r9    = {rem_ff, low_ff[7]};
      ddone = sat_ff || (cnt_ff == 4'd0);
      dval  = sat_ff ? FULL_SCALE : q_ff;
   end

   // Truncated average over up to four neighbors
   logic [7:0]  avg [3];
   logic [19:0] prod [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = 20'(sum_ff[i]) * 20'(683);
         case (t_ff)
            3'd1:    avg[i] = sum_ff[i][7:0];
            3'd2:    avg[i] = sum_ff[i][8:1];
            3'd3:    avg[i] = prod[i][18:11];
            3'd4:    avg[i] = sum_ff[i][9:2];
            default: avg[i] = res_ff[i];
         endcase
      end
   end

   logic nflag;
   always_comb begin
      case (k_ff + 3'd1)
         K_LEFT:  nflag = flags_ff.left;
         K_RIGHT: nflag = flags_ff.right;
         K_UP:    nflag = flags_ff.up;
         K_DOWN:  nflag = flags_ff.down;
         default: nflag = 1'b0;
      endcase
   end

   logic load_out;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      flags_in = flags_ff;
      pslot_in = pslot_ff;
      k_in     = k_ff;
      ch_in    = ch_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      sat_in   = sat_ff;
      pix_in   = pix_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      res_in   = res_ff;
      sum_in   = sum_ff;
      t_in     = t_ff;
      cmd_pop  = 1'b0;
      we       = 1'b0;
      re       = 1'b0;
      raddr    = pslot_ff;
      load_out = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               we       = cmd_flags.has_px;
               flags_in = cmd_flags;
               pslot_in = cmd_pslot;
               k_in     = K_CUR;
               t_in     = '0;
               for (int i = 0; i < 3; i++) sum_in[i] = '0;
               if (cmd_flags.emit) state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (k_ff == K_LEFT) begin
               pix_in   = left_ff;
               state_in = S_EVAL;
            end else begin
               re = 1'b1;
               case (k_ff)
                  K_RIGHT: raddr = right_a;
                  K_UP:    raddr = up_a;
                  K_DOWN:  raddr = dn_a;
                  default: raddr = pslot_ff;
               endcase
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            pix_in   = rdata_ff;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // start the divider on channel zero
            ch_in  = 2'd0;
            rem_in = ld_n[15:8];
            low_in = ld_n[7:0];
            q_in   = '0;
            cnt_in = 4'd8;
            sat_in = (ld_c >= pix_ff.alpha);
            if (k_ff == K_CUR) begin
               cur_in    = pix_ff;
               res_in[0] = pix_ff.first;
               res_in[1] = pix_ff.second;
               res_in[2] = pix_ff.third;
               if (!premult)                  state_in = S_OUT;
               else if (pix_ff.alpha != '0)   state_in = S_DIV;
               else                           state_in = S_NEXT;
            end else begin
               state_in = (pix_ff.alpha != '0) ? S_DIV : S_NEXT;
            end
         end
         S_DIV: begin
            if (ddone) begin
               if (k_ff == K_CUR) res_in[ch_ff] = dval;
               else               sum_in[ch_ff] = sum_ff[ch_ff] + 10'(dval);
               if (ch_ff == 2'd2) begin
                  if (k_ff == K_CUR) begin
                     state_in = S_OUT;
                  end else begin
                     t_in     = t_ff + 3'd1;
                     state_in = S_NEXT;
                  end
               end else begin
                  ch_in  = ld_ch;
                  rem_in = ld_n[15:8];
                  low_in = ld_n[7:0];
                  q_in   = '0;
                  cnt_in = 4'd8;
                  sat_in = (ld_c >= pix_ff.alpha);
               end
            end else begin
               // one restoring step
               if (r9 >= {1'b0, pix_ff.alpha}) begin
                  rem_in = 8'(r9 - {1'b0, pix_ff.alpha});
                  q_in   = {q_ff[6:0], 1'b1};
               end else begin
                  rem_in = r9[7:0];
                  q_in   = {q_ff[6:0], 1'b0};
               end
               low_in = {low_ff[6:0], 1'b0};
               cnt_in = cnt_ff - 4'd1;
            end
         end
         S_NEXT: begin
            if (k_ff == K_DOWN) begin
               state_in = S_AVG;
            end else begin
               k_in = k_ff + 3'd1;
               if (nflag) state_in = S_FETCH;
            end
         end
         S_AVG: begin
            res_in   = avg;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff || !rsp_stall) begin
               load_out = 1'b1;
               left_in  = cur_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result register
   always_comb begin
      of_in = of_ff;
      os_in = os_ff;
      ot_in = ot_ff;
      oa_in = oa_ff;
      oe_in = oe_ff;
      ov_in = ov_ff && rsp_stall;
      if (load_out) begin
         ov_in = 1'b1;
         of_in = swap ? res_ff[2] : res_ff[0];
         os_in = res_ff[1];
         ot_in = swap ? res_ff[0] : res_ff[2];
         oa_in = premult ? cur_ff.alpha : FULL_SCALE;
         oe_in = flags_ff.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         left_ff  <= left_in;
      end
      flags_ff <= flags_in;
      pslot_ff <= pslot_in;
      k_ff     <= k_in;
      ch_ff    <= ch_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      sat_ff   <= sat_in;
      pix_ff   <= pix_in;
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      sum_ff   <= sum_in;
      t_ff     <= t_in;
      of_ff    <= of_in;
      os_ff    <= os_in;
      ot_ff    <= ot_in;
      oa_ff    <= oa_in;
      oe_ff    <= oe_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_out_first    = of_ff;
   assign rsp_out_second   = os_ff;
   assign rsp_out_third    = ot_ff;
   assign rsp_out_alpha    = oa_ff;
   assign rsp_end_of_frame = oe_ff;

endmodule

`default_nettype wire

@@ rtl/ud_checker.sv @@
// ----------------------------------------------------------------------------
// ud_checker
// Port-level checks for the pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ud_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_drain,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_first,
   input wire logic [7:0]  rsp_out_second,
   input wire logic [7:0]  rsp_out_third,
   input wire logic [7:0]  rsp_out_alpha,
   input wire logic        rsp_end_of_frame
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_first)
         && $stable(rsp_out_second) && $stable(rsp_out_third)
         && $stable(rsp_out_alpha) && $stable(rsp_end_of_frame))
      else $error("stalled result changed");

   // Drop any result on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result needs fetch, evaluate and output cycles after reset
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2))
      else $error("result too soon after reset");

   // A drain into an empty store yields nothing next cycle
   a_empty_drain: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_valid && !req_stall && req_drain |=> !rsp_valid)
      else $error("result from drain of empty store");

endmodule

bind unpremultiply_defringe_pixel_stream ud_checker u_ud_checker (.*);

`default_nettype wire

@@ bench/unpremultiply_defringe_pixel_stream_checker.sv @@
// ----------------------------------------------------------------------------
// unpremultiply_defringe_pixel_stream_checker
// Watches the request, response and register channels of the pixel stream,
// keeps its own copy of the row store and frame position, predicts every
// result pixel and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unpremultiply_defringe_pixel_stream_checker
   import ud_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_drain,
   input  logic [7:0]  req_first_channel,
   input  logic [7:0]  req_second_channel,
   input  logic [7:0]  req_third_channel,
   input  logic [7:0]  req_alpha_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_first,
   input  logic [7:0]  rsp_out_second,
   input  logic [7:0]  rsp_out_third,
   input  logic [7:0]  rsp_out_alpha,
   input  logic        rsp_end_of_frame,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          outstanding,
   output int          pixels_out
);

   localparam int DIM_LIMIT   = 4096;
   localparam int STORE_DEPTH = 2 * DIM_LIMIT + 2;

   typedef struct {
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] third;
      logic [7:0] alpha;
      logic       eof;
   } out_pixel_t;

   out_pixel_t  pixel_queue[$];

   logic [12:0] width_reg, height_reg;
   logic        premult_reg, swap_reg;
   pixel_type   row_mem [STORE_DEPTH];
   int unsigned wr_slot, backlog, col_pos, row_pos;
   pixel_type   last_out;

   assign outstanding = pixel_queue.size();

   function automatic int unsigned clamp_dim(int unsigned v);
      if (v < 1) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return v;
   endfunction

   function automatic int unsigned restore(int unsigned c, int unsigned a);
      int unsigned v;
      if (a == 0) return c;
      v = (c * 255) / a;
      return (v > 255) ? 255 : v;
   endfunction

   // Advance the stream model by one transaction; queue the pixel it emits
   task automatic take_item(input logic drn, input pixel_type px);
      int unsigned w, h, ps, a, n, cnt;
      int unsigned res[3];
      int unsigned sum[3];
      int unsigned tmp;
      pixel_type   cur;
      pixel_type   nb[4];
      out_pixel_t  o;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      if (!drn) begin
         row_mem[wr_slot] = px;
         wr_slot = (wr_slot + 1) % STORE_DEPTH;
         if (backlog < STORE_DEPTH) backlog++;
         if (backlog < w + 2) return;
      end else if (backlog == 0) begin
         return;
      end
      ps  = (wr_slot + STORE_DEPTH - backlog) % STORE_DEPTH;
      cur = row_mem[ps];
      a   = cur.alpha;
      if (premult_reg) begin
         res[0] = restore(cur.first, a);
         res[1] = restore(cur.second, a);
         res[2] = restore(cur.third, a);
         if (a == 0) begin
            // average the opaque neighbors that exist and have arrived
            n = 0;
            if (col_pos > 0) begin nb[n] = last_out; n++; end
            if (col_pos + 1 < w && backlog > 1) begin
               nb[n] = row_mem[(ps + 1) % STORE_DEPTH];
               n++;
            end
            if (row_pos > 0) begin
               nb[n] = row_mem[(ps + STORE_DEPTH - w) % STORE_DEPTH];
               n++;
            end
            if (row_pos + 1 < h && backlog > w) begin
               nb[n] = row_mem[(ps + w) % STORE_DEPTH];
               n++;
            end
            sum = '{0, 0, 0};
            cnt = 0;
            for (int i = 0; i < n; i++) begin
               if (nb[i].alpha != 0) begin
                  sum[0] += restore(nb[i].first, nb[i].alpha);
                  sum[1] += restore(nb[i].second, nb[i].alpha);
                  sum[2] += restore(nb[i].third, nb[i].alpha);
                  cnt++;
               end
            end
            if (cnt > 0)
               for (int i = 0; i < 3; i++) res[i] = sum[i] / cnt;
         end
         o.alpha = 8'(a);
      end else begin
         res[0]  = cur.first;
         res[1]  = cur.second;
         res[2]  = cur.third;
         o.alpha = FULL_SCALE;
      end
      if (swap_reg) begin
         tmp = res[0]; res[0] = res[2]; res[2] = tmp;
      end
      o.first  = 8'(res[0]);
      o.second = 8'(res[1]);
      o.third  = 8'(res[2]);
      o.eof    = (col_pos + 1 >= w && row_pos + 1 >= h);
      pixel_queue.push_back(o);
      last_out = cur;
      backlog--;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // Compare one returned pixel against the oldest prediction
   task automatic check_result();
      out_pixel_t e;
      if (pixel_queue.size() == 0) begin
         $error("unexpected result pixel %h %h %h %h eof %b", rsp_out_first,
                rsp_out_second, rsp_out_third, rsp_out_alpha, rsp_end_of_frame);
         mismatches++;
         return;
      end
      e = pixel_queue.pop_front();
      if (rsp_out_first !== e.first) begin
         $error("out_first: expected %0d, got %0d", e.first, rsp_out_first);
         mismatches++;
      end
      if (rsp_out_second !== e.second) begin
         $error("out_second: expected %0d, got %0d", e.second, rsp_out_second);
         mismatches++;
      end
      if (rsp_out_third !== e.third) begin
         $error("out_third: expected %0d, got %0d", e.third, rsp_out_third);
         mismatches++;
      end
      if (rsp_out_alpha !== e.alpha) begin
         $error("out_alpha: expected %0d, got %0d", e.alpha, rsp_out_alpha);
         mismatches++;
      end
      if (rsp_end_of_frame !== e.eof) begin
         $error("end_of_frame: expected %0d, got %0d", e.eof, rsp_end_of_frame);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      pixels_out = 0;
   end

   // Track register writes, accepted requests and accepted results
   always @(posedge clock) begin
      pixel_type px;
      if (reset) begin
         width_reg   = 13'd640;
         height_reg  = 13'd480;
         premult_reg = 1'b0;
         swap_reg    = 1'b1;
         wr_slot     = 0;
         backlog     = 0;
         col_pos     = 0;
         row_pos     = 0;
         last_out    = '0;
         pixel_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
            pixels_out++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg   = csr_wdata[12:0];
               CSR_FRAME_HEIGHT: height_reg  = csr_wdata[12:0];
               CSR_PREMULT:      premult_reg = csr_wdata[0];
               CSR_SWAP:         swap_reg    = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            px.first  = req_first_channel;
            px.second = req_second_channel;
            px.third  = req_third_channel;
            px.alpha  = req_alpha_in;
            take_item(req_drain, px);
         end
      end
   end

endmodule

@@ bench/unpremultiply_defringe_pixel_stream_tb.sv @@
// ----------------------------------------------------------------------------
// unpremultiply_defringe_pixel_stream_tb
// Drives raster pixel frames and drain transactions into the block under a
// series of frame geometries and modes (clamped extremes included), with
// random gaps on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unpremultiply_defringe_pixel_stream_tb;
   import ud_pkg::*;

   localparam int IDLE_LIMIT   = 20000;
   localparam int SETTLE       = 150;
   localparam int PIXEL_TARGET = 1800;

   logic        clock, reset;
   logic        req_valid, req_stall, req_drain;
   logic [7:0]  req_first_channel, req_second_channel, req_third_channel;
   logic [7:0]  req_alpha_in;
   logic        rsp_valid, rsp_stall;
   logic [7:0]  rsp_out_first, rsp_out_second, rsp_out_third, rsp_out_alpha;
   logic        rsp_end_of_frame;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_wdata;

   int          mismatches, outstanding, pixels_out;
   int          tx_gap_pct, rx_gap_pct, idle_cycles;
   int          pixels_sent, drains_sent, phases;
   int unsigned frame_w, backlog;

   unpremultiply_defringe_pixel_stream dut (.*);

   unpremultiply_defringe_pixel_stream_checker checker_i (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_gap_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("unpremultiply_defringe_pixel_stream_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one transaction and hold it until accepted
   task automatic send_item(input logic drn, input logic [7:0] f, input logic [7:0] s,
                            input logic [7:0] t, input logic [7:0] a);
      logic go;
      while ($urandom_range(99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_drain          <= drn;
      req_first_channel  <= f;
      req_second_channel <= s;
      req_third_channel  <= t;
      req_alpha_in       <= a;
      forever begin
         @(negedge clock);
         go = !req_stall;
         @(posedge clock);
         if (go) break;
      end
      if (!drn) begin
         pixels_sent++;
         backlog++;
         if (backlog >= frame_w + 2) backlog--;
      end else begin
         drains_sent++;
         if (backlog > 0) backlog--;
      end
   endtask

   task automatic send_pixel(input logic [7:0] f, input logic [7:0] s,
                             input logic [7:0] t, input logic [7:0] a);
      send_item(1'b0, f, s, t, a);
   endtask

   // Push out every pending pixel and let the block go idle
   task automatic flush_frame();
      while (backlog > 0) send_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
      logic go;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      forever begin
         @(negedge clock);
         go = csr_ready;
         @(posedge clock);
         if (go) break;
      end
   endtask

   // Drain, then program a new geometry and mode
   task automatic set_mode(input int unsigned w, input int unsigned h,
                           input logic pm, input logic sw);
      flush_frame();
      write_reg(CSR_FRAME_WIDTH, 16'(w));
      write_reg(CSR_FRAME_HEIGHT, 16'(h));
      write_reg(CSR_PREMULT, {15'd0, pm});
      write_reg(CSR_SWAP, {15'd0, sw});
      csr_valid <= 1'b0;
      frame_w = (w < 1) ? 1 : (w > 4096) ? 4096 : w;
      phases++;
   endtask

   // Well-formed premultiplied pixels, transparent and raw ones, and some drains
   task automatic send_random();
      int unsigned r, a;
      r = $urandom_range(99);
      if (r < 3) begin
         send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         return;
      end
      a = (r < 33) ? 0 : (r < 40) ? 255 : $urandom_range(1, 255);
      if (a != 0 && r < 80)
         send_pixel(8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                    8'($urandom_range(0, a)), 8'(a));
      else
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'(a));
   endtask

   initial begin
      int unsigned w, h, n, sel;
      bit paused;
      reset = 1'b1;
      req_valid = 1'b0; req_drain = 1'b0;
      req_first_channel = '0; req_second_channel = '0;
      req_third_channel = '0; req_alpha_in = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      idle_cycles = 0;
      tx_gap_pct = 35; rx_gap_pct = 50;
      pixels_sent = 0; drains_sent = 0; phases = 0;
      frame_w = 640; backlog = 0;
      paused = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 4x3 frame, transparent pixels at corner, edge and interior
      set_mode(4, 3, 1'b1, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd128, 8'd0, 8'd1);
      send_pixel(8'd10, 8'd20, 8'd30, 8'd40);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd200, 8'd100, 8'd50, 8'd200);
      send_pixel(8'd77, 8'd1, 8'd254, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(8'd3, 8'd2, 8'd1, 8'd128);
      send_pixel(8'd9, 8'd9, 8'd9, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255, 8'd254);
      flush_frame();
      // drain with nothing pending yields nothing
      send_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
      // zero geometry acts as 1x1; alpha forced to full scale
      set_mode(0, 0, 1'b0, 1'b1);
      send_pixel(8'd1, 8'd2, 8'd3, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd128, 8'd99);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      // oversize geometry clamps to the maximum
      set_mode(8191, 8191, 1'b1, 1'b1);
      repeat (8) send_random();

      // Random phases with changing geometry and idling profile
      while (pixels_sent + drains_sent < PIXEL_TARGET) begin
         if (pixels_sent + drains_sent >= 1200) begin
            tx_gap_pct = 0;  rx_gap_pct = 0;
         end else if (pixels_sent + drains_sent >= 600) begin
            tx_gap_pct = 50; rx_gap_pct = 35;
         end
         sel = $urandom_range(9);
         case (sel)
            0:       begin w = 0;    h = 0; end
            1:       begin w = 8191; h = 2; end
            2:       begin w = 1;    h = $urandom_range(1, 6); end
            3:       begin w = 3;    h = 8191; end
            4:       begin w = 4096; h = 4096; end
            default: begin w = $urandom_range(2, 16); h = $urandom_range(1, 8); end
         endcase
         set_mode(w, h, 1'($urandom), 1'($urandom));
         if (frame_w > 16) n = 60;
         else n = $urandom_range(1, 3) * frame_w * ((h > 8) ? 5 : (h < 1) ? 1 : h);
         if (n > 200) n = 200;
         repeat (n) begin
            send_random();
            // hold the sender until the block has caught up
            if (!paused && pixels_sent + drains_sent >= 900) begin
               paused = 1;
               req_valid <= 1'b0;
               do @(posedge clock); while (outstanding != 0);
            end
         end
      end
      flush_frame();

      $display("covered %0d pixels and %0d drains over %0d register settings",
               pixels_sent, drains_sent, phases);
      $display("checked %0d result pixels", pixels_out);
      if (mismatches == 0) begin
         $display("unpremultiply_defringe_pixel_stream_tb: done, clean");
      end else begin
         $display("unpremultiply_defringe_pixel_stream_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ud_pkg.sv
rtl/ud_queue.sv
rtl/ud_front.sv
rtl/ud_back.sv
rtl/unpremultiply_defringe_pixel_stream.sv
rtl/ud_checker.sv
bench/unpremultiply_defringe_pixel_stream_checker.sv
bench/unpremultiply_defringe_pixel_stream_tb.sv
